[rtl/core/ggvc_pkg.sv]
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller package
// Shared types, register indexes and constant tables for the controller.
// ----------------------------------------------------------------------------
package ggvc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_GOAL_X       = 3'd0;
    localparam logic [2:0] REG_GOAL_Y       = 3'd1;
    localparam logic [2:0] REG_HEADING_GAIN = 3'd2;
    localparam logic [2:0] REG_ARRIVE_TOL   = 3'd3;
    localparam logic [2:0] REG_LINEAR_LIM   = 3'd4;
    localparam logic [2:0] REG_ANGULAR_LIM  = 3'd5;

    // Width of the vector components inside the rotation chain.
    localparam int VW = 45;
    // Width of an accumulated angle in Q30 radians.
    localparam int AW = 34;
    // Bits of the radicand and of the root accumulator.
    localparam int SQ_W = 64;
    // The square root resolves two radicand bits per cell.
    localparam int SQRT_STEPS = 32;
    // Bit position that the normalised vector magnitude reaches.
    localparam int NORM_TOP = 40;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    // One vector whose angle is being resolved.
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } ggvc_vec_t;

    // Everything one item carries down the chain.
    typedef struct packed {
        ggvc_vec_t         yaw;
        ggvc_vec_t         brg;
        logic [SQ_W-1:0]   rem;
        logic [SQ_W-1:0]   root;
        logic              arrived;
    } ggvc_data_t;

endpackage

[rtl/core/go_to_goal_velocity_controller.sv]
// Throughput: one item per cycle; the 32-cell square-root chain, rotating in its first
// CORDIC_STEPS cells, makes up most of the depth. The whole pipeline holds while a result
// waits under out_stall. Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller
// Turns an odometry sample into a clamped linear and angular speed command.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        linear_speed,
    output logic signed [31:0] angular_speed,
    output logic               arrived,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [31:0]        wr_data
);

    localparam int NSTEP  = 6;
    localparam int NCELL  = ggvc_pkg::SQRT_STEPS;
    localparam int PW     = 52;

    logic               en;

    // Configuration registers.
    logic signed [31:0] goal_x_reg;
    logic signed [31:0] goal_y_reg;
    logic [15:0]        gain_reg;
    logic [30:0]        tol_reg;
    logic [30:0]        lin_lim_reg;
    logic [30:0]        ang_lim_reg;

    // First stage: errors and quaternion products.
    logic               v1_reg;
    logic signed [31:0] ex_reg;
    logic signed [31:0] ey_reg;
    logic signed [31:0] pwz_reg;
    logic signed [31:0] pxy_reg;
    logic signed [31:0] pyy_reg;
    logic signed [31:0] pzz_reg;
    logic signed [31:0] ex_next;
    logic signed [31:0] ey_next;

    // Second stage: vectors, arrival and radicand.
    logic                 v2_reg;
    ggvc_pkg::ggvc_data_t d2_reg;
    ggvc_pkg::ggvc_data_t d2_next;

    logic                 nv   [NSTEP+1];
    ggvc_pkg::ggvc_data_t nd   [NSTEP+1];
    logic                 v3_reg;
    ggvc_pkg::ggvc_data_t d3_reg;
    ggvc_pkg::ggvc_data_t d3_next;
    logic                 cv   [NCELL+1];
    ggvc_pkg::ggvc_data_t cd   [NCELL+1];

    // Product stage.
    logic                 vm_reg;
    logic signed [PW-1:0] prod_reg;
    logic [32:0]          root_reg;
    logic                 arr_m_reg;
    logic signed [ggvc_pkg::AW:0] herr;

    // Output stage.
    logic                 out_valid_reg;
    logic [30:0]          lin_reg;
    logic signed [31:0]   ang_reg;
    logic                 arr_reg;
    logic signed [PW-1:0] ang_round;
    logic signed [PW-1:0] lim_pos;
    logic [30:0]          lin_next;
    logic signed [31:0]   ang_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg  <= 32'sd65536;
            goal_y_reg  <= 32'sd655360;
            gain_reg    <= 16'd2560;
            tol_reg     <= 31'd6554;
            lin_lim_reg <= 31'd65536;
            ang_lim_reg <= 31'd65536;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ggvc_pkg::REG_GOAL_X:       goal_x_reg  <= wr_data;
                ggvc_pkg::REG_GOAL_Y:       goal_y_reg  <= wr_data;
                ggvc_pkg::REG_HEADING_GAIN: gain_reg    <= wr_data[15:0];
                ggvc_pkg::REG_ARRIVE_TOL:   tol_reg     <= wr_data[30:0];
                ggvc_pkg::REG_LINEAR_LIM:   lin_lim_reg <= wr_data[30:0];
                ggvc_pkg::REG_ANGULAR_LIM:  ang_lim_reg <= wr_data[30:0];
                default:                    ;
            endcase
        end
    end

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
        begin
            return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return d[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    assign ex_next = sat_sub(goal_x_reg, pos_x);
    assign ey_next = sat_sub(goal_y_reg, pos_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vm_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= nv[NSTEP];
            vm_reg <= cv[NCELL];
            out_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg  <= ex_next;
            ey_reg  <= ey_next;
            pwz_reg <= quat_w * quat_z;
            pxy_reg <= quat_x * quat_y;
            pyy_reg <= quat_y * quat_y;
            pzz_reg <= quat_z * quat_z;
        end
    end

    always_comb
    begin
        logic signed [32:0] num_half;
        logic signed [32:0] sq_half;
        logic signed [33:0] num;
        logic signed [33:0] den;
        logic signed [63:0] sqx;
        logic signed [63:0] sqy;
        num_half = {pwz_reg[31], pwz_reg} + {pxy_reg[31], pxy_reg};
        sq_half  = {pyy_reg[31], pyy_reg} + {pzz_reg[31], pzz_reg};
        num      = {num_half, 1'b0};
        den      = (34'sd1 <<< 28) - {sq_half, 1'b0};
        sqx      = ex_reg * ex_reg;
        sqy      = ey_reg * ey_reg;
        d2_next.yaw.x    = ggvc_pkg::VW'(den);
        d2_next.yaw.y    = ggvc_pkg::VW'(num);
        d2_next.yaw.ang  = '0;
        d2_next.yaw.zero = (den == '0) && (num == '0);
        d2_next.brg.x    = ggvc_pkg::VW'(ex_reg);
        d2_next.brg.y    = ggvc_pkg::VW'(ey_reg);
        d2_next.brg.ang  = '0;
        d2_next.brg.zero = (ex_reg == '0) && (ey_reg == '0);
        d2_next.rem      = 64'(sqx) + 64'(sqy);
        d2_next.root     = '0;
        d2_next.arrived  = (abs32(ex_reg) < {1'b0, tol_reg}) &&
                           (abs32(ey_reg) < {1'b0, tol_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg <= d2_next;
        end
    end

    // Binary normalisation: shifts of 32, 16, 8, 4, 2 and 1.
    assign nv[0] = v2_reg;
    assign nd[0] = d2_reg;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_norm
        ggvc_norm #(
            .SHIFT (1 << (NSTEP - 1 - k))
        ) u_norm (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (nv[k]),
            .data_in   (nd[k]),
            .valid_out (nv[k+1]),
            .data_out  (nd[k+1])
        );
    end

    function automatic ggvc_pkg::ggvc_vec_t pre_rot(input ggvc_pkg::ggvc_vec_t v);
        ggvc_pkg::ggvc_vec_t r;
        r = v;
        // A vector in the left half-plane is first turned by a quarter turn.
        if (v.x < 0)
        begin
            if (v.y >= 0)
            begin
                r.x   = v.y;
                r.y   = -v.x;
                r.ang = $signed({3'b000, ggvc_pkg::HALF_PI_Q30});
            end
            else
            begin
                r.x   = -v.y;
                r.y   = v.x;
                r.ang = -$signed({3'b000, ggvc_pkg::HALF_PI_Q30});
            end
        end
        return r;
    endfunction

    always_comb
    begin
        d3_next     = nd[NSTEP];
        d3_next.yaw = pre_rot(nd[NSTEP].yaw);
        d3_next.brg = pre_rot(nd[NSTEP].brg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg <= d3_next;
        end
    end

    assign cv[0] = v3_reg;
    assign cd[0] = d3_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        ggvc_cell #(
            .IDX    (i),
            .ROTATE (i < CORDIC_STEPS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cv[i]),
            .data_in   (cd[i]),
            .valid_out (cv[i+1]),
            .data_out  (cd[i+1])
        );
    end

    // A zero vector has angle zero whatever the rotations left behind.
    always_comb
    begin
        logic signed [ggvc_pkg::AW-1:0] brg_ang;
        logic signed [ggvc_pkg::AW-1:0] yaw_ang;
        brg_ang = cd[NCELL].brg.zero ? '0 : cd[NCELL].brg.ang;
        yaw_ang = cd[NCELL].yaw.zero ? '0 : cd[NCELL].yaw.ang;
        herr    = {brg_ang[ggvc_pkg::AW-1], brg_ang} - {yaw_ang[ggvc_pkg::AW-1], yaw_ang};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= PW'($signed({1'b0, gain_reg})) * PW'(herr);
            root_reg  <= cd[NCELL].root[32:0];
            arr_m_reg <= cd[NCELL].arrived;
        end
    end

    assign ang_round = (prod_reg + (PW'(1) <<< 21)) >>> 22;
    assign lim_pos   = PW'($signed({1'b0, ang_lim_reg}));

    always_comb
    begin
        lin_next = (root_reg > {2'b00, lin_lim_reg}) ? lin_lim_reg : root_reg[30:0];
        if (ang_round > lim_pos)
        begin
            ang_next = lim_pos[31:0];
        end
        else if (ang_round < -lim_pos)
        begin
            ang_next = 32'(-lim_pos);
        end
        else
        begin
            ang_next = ang_round[31:0];
        end
        if (arr_m_reg)
        begin
            lin_next = '0;
            ang_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
            arr_reg <= arr_m_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = lin_reg;
    assign angular_speed = ang_reg;
    assign arrived       = arr_reg;

endmodule

[rtl/core/ggvc_norm.sv]
// ----------------------------------------------------------------------------
// Normalisation step
// Multiplies each vector of an item by a fixed power of two if the shift keeps
// its magnitude within the normalisation bound.
// ----------------------------------------------------------------------------
module ggvc_norm #(
    parameter int SHIFT = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  ggvc_pkg::ggvc_data_t data_in,
    output logic                valid_out,
    output ggvc_pkg::ggvc_data_t data_out
);

    logic                 valid_reg;
    ggvc_pkg::ggvc_data_t data_reg;
    ggvc_pkg::ggvc_data_t data_next;

    function automatic ggvc_pkg::ggvc_vec_t norm_step(input ggvc_pkg::ggvc_vec_t v);
        logic [ggvc_pkg::VW-1:0] ax;
        logic [ggvc_pkg::VW-1:0] ay;
        logic [ggvc_pkg::VW-1:0] m;
        ggvc_pkg::ggvc_vec_t     r;
        ax = v.x[ggvc_pkg::VW-1] ? ggvc_pkg::VW'(-v.x) : ggvc_pkg::VW'(v.x);
        ay = v.y[ggvc_pkg::VW-1] ? ggvc_pkg::VW'(-v.y) : ggvc_pkg::VW'(v.y);
        m  = ax | ay;
        r  = v;
        // Shift only if the top bits that the shift would fill are still clear.
        if ((m >> (ggvc_pkg::NORM_TOP + 1 - SHIFT)) == '0)
        begin
            r.x = v.x <<< SHIFT;
            r.y = v.y <<< SHIFT;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next     = data_in;
        data_next.yaw = norm_step(data_in.yaw);
        data_next.brg = norm_step(data_in.brg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[rtl/core/ggvc_cell.sv]
// ----------------------------------------------------------------------------
// Chain cell
// One micro-rotation of both angle vectors, where ROTATE is set, and one digit
// pair of the integer square root, registered and handed to the next cell.
// ----------------------------------------------------------------------------
module ggvc_cell #(
    parameter int IDX    = 0,
    parameter bit ROTATE = 1'b1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  ggvc_pkg::ggvc_data_t data_in,
    output logic                valid_out,
    output ggvc_pkg::ggvc_data_t data_out
);

    localparam logic [ggvc_pkg::SQ_W-1:0] SQ_BIT =
        ggvc_pkg::SQ_W'(1) << (2 * (ggvc_pkg::SQRT_STEPS - 1 - IDX));
    localparam logic signed [ggvc_pkg::AW-1:0] ATAN_STEP =
        $signed({4'b0000, ggvc_pkg::ATAN_TAB[IDX]});

    logic                         valid_reg;
    ggvc_pkg::ggvc_data_t         data_reg;
    ggvc_pkg::ggvc_data_t         data_next;
    logic [ggvc_pkg::SQ_W-1:0]    trial;

    function automatic ggvc_pkg::ggvc_vec_t rot_step(input ggvc_pkg::ggvc_vec_t v);
        logic signed [ggvc_pkg::VW-1:0] dx;
        logic signed [ggvc_pkg::VW-1:0] dy;
        ggvc_pkg::ggvc_vec_t            r;
        dx = v.y >>> IDX;
        dy = v.x >>> IDX;
        r  = v;
        if (v.y > 0)
        begin
            r.x   = v.x + dx;
            r.y   = v.y - dy;
            r.ang = v.ang + ATAN_STEP;
        end
        else
        begin
            r.x   = v.x - dx;
            r.y   = v.y + dy;
            r.ang = v.ang - ATAN_STEP;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next = data_in;
        trial     = data_in.root + SQ_BIT;
        if (ROTATE)
        begin
            data_next.yaw = rot_step(data_in.yaw);
            data_next.brg = rot_step(data_in.brg);
        end
        if (data_in.rem >= trial)
        begin
            data_next.rem  = data_in.rem - trial;
            data_next.root = (data_in.root >> 1) + SQ_BIT;
        end
        else
        begin
            data_next.root = data_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[rtl/core/ggvc_checker.sv]
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller checker
// Port-level assertions on the controller, attached by a bind.
// ----------------------------------------------------------------------------
module ggvc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [30:0]        linear_speed,
    input logic signed [31:0] angular_speed,
    input logic               arrived
);

    // A result held under stall keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(linear_speed) &&
        $stable(angular_speed) && $stable(arrived))
        else $error("stalled result changed");

    // An arrived item commands no motion.
    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arrived |-> linear_speed == '0 && angular_speed == '0)
        else $error("arrived item with nonzero speed");

    // Input is held back exactly when a result is blocked.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output blocking");

    // No result is offered during reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered in reset");

endmodule

bind go_to_goal_velocity_controller ggvc_checker u_ggvc_checker (.*);

[sim/go_to_goal_velocity_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller testbench
// Drives odometry samples through the controller with random idling on both
// sides, predicts each speed command with a bit-exact model of the fixed-point
// arithmetic, and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_tb;

    localparam int STEPS = 16;
    localparam int LATENCY = 43;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint PRESCALE = 64'sd1 << 40;

    typedef struct {
        logic [30:0]        lin;
        logic signed [31:0] ang;
        logic               arr;
    } command_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               out_valid;
    logic               out_stall;
    logic [30:0]        linear_speed;
    logic signed [31:0] angular_speed;
    logic               arrived;
    logic               wr_en;
    logic [2:0]         wr_index;
    logic [31:0]        wr_data;

    // Shadow copy of the controller's registers.
    longint goal_x_q, goal_y_q, gain_q, tol_q, lin_lim_q, ang_lim_q;

    command_t expected_cmds[$];
    int       error_count;
    int       idle_cycles;
    bit       gaps_on;
    bit       hold_receiver;

    go_to_goal_velocity_controller #(.CORDIC_STEPS(STEPS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .linear_speed(linear_speed), .angular_speed(angular_speed),
        .arrived(arrived),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Angle of the vector (x, y) in Q30 radians by vectoring rotation.
    function automatic longint vector_angle(longint x, longint y);
        longint a, t, dx, dy;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        while (abs64(x) < PRESCALE && abs64(y) < PRESCALE)
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                a = HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                a = -HALF_PI;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + longint'(ggvc_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                a = a - longint'(ggvc_pkg::ATAN_TAB[i]);
            end
        end
        return a;
    endfunction

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic command_t steer_command(longint px, longint py, longint qx,
                                               longint qy, longint qz, longint qw);
        command_t c;
        longint ex, ey, num, den, yaw, brg, lin, ang;
        logic [63:0] sq;
        ex = sat32(goal_x_q - px);
        ey = sat32(goal_y_q - py);
        c.lin = '0;
        c.ang = '0;
        c.arr = 1'b0;
        if (abs64(ex) < tol_q && abs64(ey) < tol_q)
            c.arr = 1'b1;
        else
        begin
            num = 2 * (qw * qz + qx * qy);
            den = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
            yaw = vector_angle(den, num);
            brg = vector_angle(ex, ey);
            sq = 64'(ex * ex) + 64'(ey * ey);
            lin = int_sqrt(sq);
            if (lin > lin_lim_q)
                lin = lin_lim_q;
            ang = floor_shift(gain_q * (brg - yaw) + (64'sd1 << 21), 22);
            if (ang > ang_lim_q)
                ang = ang_lim_q;
            if (ang < -ang_lim_q)
                ang = -ang_lim_q;
            c.lin = lin[30:0];
            c.ang = ang[31:0];
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            ggvc_pkg::REG_GOAL_X:       goal_x_q = longint'(signed'(value));
            ggvc_pkg::REG_GOAL_Y:       goal_y_q = longint'(signed'(value));
            ggvc_pkg::REG_HEADING_GAIN: gain_q = longint'(value[15:0]);
            ggvc_pkg::REG_ARRIVE_TOL:   tol_q = longint'(value[30:0]);
            ggvc_pkg::REG_LINEAR_LIM:   lin_lim_q = longint'(value[30:0]);
            ggvc_pkg::REG_ANGULAR_LIM:  ang_lim_q = longint'(value[30:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Offers one item, with an optional random gap first, and waits until it is accepted.
    task automatic send_sample(logic [31:0] px, logic [31:0] py, logic [15:0] qx,
                               logic [15:0] qy, logic [15:0] qz, logic [15:0] qw);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        quat_w <= qw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_cmds.push_back(steer_command(longint'(signed'(px)),
            longint'(signed'(py)), longint'(signed'(qx)), longint'(signed'(qy)),
            longint'(signed'(qz)), longint'(signed'(qw))));
    endtask

    function automatic logic [15:0] rand_quat();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // One sample in four lies within 10000 of the goal, so arrival and small errors occur.
    task automatic send_random_sample();
        logic [31:0] px, py;
        case ($urandom_range(0, 3))
            0:
            begin
                px = $urandom;
                py = $urandom;
            end
            1:
            begin
                px = 32'(goal_x_q) + 32'($signed($urandom_range(0, 20000)) - 10000);
                py = 32'(goal_y_q) + 32'($signed($urandom_range(0, 20000)) - 10000);
            end
            default:
            begin
                px = 32'(goal_x_q) + 32'($signed($urandom_range(0, 2000000)) - 1000000);
                py = 32'(goal_y_q) + 32'($signed($urandom_range(0, 2000000)) - 1000000);
            end
        endcase
        send_sample(px, py, rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endtask

    task automatic test_directed();
        send_sample(32'h0001_0000, 32'h000A_0000, 0, 0, 0, 16'sd16384);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 16'sd16384);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'sd16384, 16'sd16384,
                    16'sd16384, 16'sd16384);
        send_sample(0, 0, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        // Yaw vector of nearly zero length: 2(y*y + z*z) is close to one and wz + xy is zero.
        send_sample(0, 0, 0, 16'sd11585, 0, 0);
        send_sample(0, 0, 0, 0, 16'sd11585, 0);
        send_sample(32'h0001_0000, 32'h0009_0000, 0, 0, 16'sd16384, 0);
        send_sample(32'h0001_0000, 32'h000B_0000, 0, 0, -16'sd16384, 16'sd100);
        send_sample(32'h0005_0000, 32'h000A_0000, 0, 0, 0, 16'sd16384);
        send_sample(32'hFFFB_0000, 32'hFFF0_0000, 16'sd3000, -16'sd7000, 16'sd200, 0);
        // Errors exactly at and just below the tolerance.
        send_sample(32'h0001_0000 - 6554, 32'h000A_0000, 0, 0, 0, 16'sd16384);
        send_sample(32'h0001_0000 - 6553, 32'h000A_0000 + 6553, 0, 0, 0, 16'sd16384);
        send_sample(32'h0001_0000, 32'h000A_0000 - 6554, 0, 0, 0, 16'sd16384);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 16'h1234, 16'h0F0F);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        logic [31:0] settings [4][6];
        settings[0] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        settings[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                        32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        settings[2] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF,
                        32'h0000_0100, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        settings[3] = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        for (int s = 0; s < 4; s++)
        begin
            for (int r = 0; r < 6; r++)
                write_register(3'(r), settings[s][r]);
            write_register(3'd7, $urandom);
            for (int n = 0; n < 40; n++)
                send_random_sample();
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        write_register(ggvc_pkg::REG_GOAL_X, 32'h0003_0000);
        write_register(ggvc_pkg::REG_GOAL_Y, 32'hFFFE_0000);
        write_register(ggvc_pkg::REG_HEADING_GAIN, 32'd2560);
        write_register(ggvc_pkg::REG_ARRIVE_TOL, 32'd6554);
        write_register(ggvc_pkg::REG_LINEAR_LIM, 32'h0002_0000);
        write_register(ggvc_pkg::REG_ANGULAR_LIM, 32'h0003_0000);
        for (int n = 0; n < 300; n++)
            send_random_sample();
        wait_drained();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall.
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        for (int n = 0; n < 80; n++)
            send_random_sample();
        wait_drained();
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        for (int n = 0; n < 150; n++)
            send_random_sample();
    endtask

    // Receiver stalls in random bursts, with a long hold when asked.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                hold_receiver = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        command_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                report_mismatch("unexpected result", longint'(1), longint'(0));
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (linear_speed !== want.lin)
                    report_mismatch("linear_speed", longint'(linear_speed),
                                    longint'(want.lin));
                if (angular_speed !== want.ang)
                    report_mismatch("angular_speed", longint'(angular_speed),
                                    longint'(want.ang));
                if (arrived !== want.arr)
                    report_mismatch("arrived", longint'(arrived), longint'(want.arr));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with no progress");
            $display("** go_to_goal_velocity_controller: FAILED **");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        hold_receiver = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        quat_w = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        goal_x_q = 65536;
        goal_y_q = 655360;
        gain_q = 2560;
        tol_q = 6554;
        lin_lim_q = 65536;
        ang_lim_q = 65536;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_full_rate();
        wait_drained();
        if (expected_cmds.size() != 0)
            report_mismatch("outstanding results", longint'(expected_cmds.size()),
                            longint'(0));
        if (error_count == 0)
            $display("** go_to_goal_velocity_controller: PASSED **");
        else
            $display("** go_to_goal_velocity_controller: FAILED **");
        $finish;
    end
endmodule
